// ----- hdl/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared widths, frame state codes, register indexes and interface structs
// for the contiguous frame allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int ADDR_W     = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = ADDR_W + 1;
    localparam int FRAME_W    = 20;
    localparam int CFG_IDX_W  = 2;

    // Frame state codes held in the store.
    localparam logic [1:0] ST_FREE = 2'b00;
    localparam logic [1:0] ST_USED = 2'b01;
    localparam logic [1:0] ST_HEAD = 2'b10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_SIZE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVE_FIRST = 2'd2;

    typedef struct packed {
        logic [FRAME_W-1:0] pool_base;
        logic [COUNT_W-1:0] pool_limit;
        logic               reserve_first;
    } cfg_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        wdata;
    } mem_req_t;

endpackage

// ----- hdl/cfa_frame_ram.sv -----
// ----------------------------------------------------------------------------
// cfa_frame_ram
// Single-port synchronous store of the 2-bit frame states, with a registered read.
// ----------------------------------------------------------------------------
module cfa_frame_ram (
    input  logic             clk,
    input  cfa_pkg::mem_req_t req,
    output logic [1:0]       rdata
);

    logic [1:0] mem [cfa_pkg::MAX_FRAMES];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cfa_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cfa_cfg_regs
// Configuration registers; the pool size is saturated to the store depth.
// ----------------------------------------------------------------------------
module cfa_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfa_pkg::FRAME_W-1:0]      cfg_wdata,
    output cfa_pkg::cfg_t                    cfg
);

    localparam logic [cfa_pkg::COUNT_W-1:0] LIMIT_MAX =
        cfa_pkg::COUNT_W'(cfa_pkg::MAX_FRAMES);

    logic [cfa_pkg::FRAME_W-1:0] pool_base_reg;
    logic [10:0]                 pool_size_reg;
    logic                        reserve_first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg     <= '0;
            pool_size_reg     <= 11'd1024;
            reserve_first_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfa_pkg::REG_POOL_BASE:     pool_base_reg     <= cfg_wdata;
                cfa_pkg::REG_POOL_SIZE:     pool_size_reg     <= cfg_wdata[10:0];
                cfa_pkg::REG_RESERVE_FIRST: reserve_first_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pool_base     = pool_base_reg;
        cfg.reserve_first = reserve_first_reg;
        if ({{(cfa_pkg::COUNT_W){1'b0}}, pool_size_reg} >
            {11'd0, LIMIT_MAX})
        begin
            cfg.pool_limit = LIMIT_MAX;
        end
        else
        begin
            cfg.pool_limit = cfa_pkg::COUNT_W'(pool_size_reg);
        end
    end

endmodule

// ----- hdl/cfa_scan_ctrl.sv -----
// ----------------------------------------------------------------------------
// cfa_scan_ctrl
// Sequencer: clearing pass, first-fit scan over the store with one read in
// flight per cycle, marking of the found run, and the result register.
// ----------------------------------------------------------------------------
module cfa_scan_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfa_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cfa_pkg::COUNT_W-1:0]   req_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [cfa_pkg::FRAME_W-1:0]   first_frame,
    output cfa_pkg::mem_req_t             mem_req,
    input  logic [1:0]                    mem_rdata
);

    localparam int AW = cfa_pkg::ADDR_W;
    localparam int CW = cfa_pkg::COUNT_W;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] want_reg, want_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic [AW-1:0] ev_off_reg, ev_off_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [CW-1:0] run_reg, run_next;
    logic [AW-1:0] start_reg, start_next;
    logic [CW-1:0] mark_reg, mark_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    logic          granted_reg, granted_next;
    logic [cfa_pkg::FRAME_W-1:0] first_frame_reg, first_frame_next;

    logic          frame_free;
    logic          found;
    logic          issue;
    logic [AW-1:0] run_start;
    logic          out_free;

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign granted     = granted_reg;
    assign first_frame = first_frame_reg;
    assign out_free    = !out_valid_reg || !out_stall;

    always_comb
    begin
        frame_free = (mem_rdata == cfa_pkg::ST_FREE) &&
                     !((ev_off_reg == '0) && cfg.reserve_first);
        run_start  = (run_reg == '0) ? ev_off_reg : start_reg;
        found      = rd_vld_reg && frame_free && ((run_reg + 1'b1) == want_reg);
        issue      = (state_reg == S_SCAN) && (iss_reg < cfg.pool_limit) && !found;
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        want_next        = want_reg;
        iss_next         = iss_reg;
        ev_off_next      = ev_off_reg;
        rd_vld_next      = 1'b0;
        run_next         = run_reg;
        start_next       = start_reg;
        mark_next        = mark_reg;
        hit_next         = hit_reg;
        granted_next     = granted_reg;
        first_frame_next = first_frame_reg;
        out_valid_next   = out_valid_reg && out_stall;

        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = iss_reg[AW-1:0];
        mem_req.wdata = cfa_pkg::ST_FREE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_reg;
                mem_req.wdata = cfa_pkg::ST_FREE;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == AW'(cfa_pkg::MAX_FRAMES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    want_next = req_count;
                    iss_next  = '0;
                    run_next  = '0;
                    hit_next  = 1'b0;
                    state_next = (req_count == '0) ? S_DONE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Reads are issued back to back; each result is judged in the cycle
                // after its read is issued, against the running length of free frames.
                mem_req.re  = issue;
                rd_vld_next = issue;
                ev_off_next = iss_reg[AW-1:0];
                if (issue)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (frame_free)
                    begin
                        start_next = run_start;
                        run_next   = run_reg + 1'b1;
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (found)
                begin
                    hit_next   = 1'b1;
                    mark_next  = '0;
                    state_next = S_MARK;
                end
                else if (!issue && !rd_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_MARK:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = start_reg + mark_reg[AW-1:0];
                mem_req.wdata = (mark_reg == '0) ? cfa_pkg::ST_HEAD : cfa_pkg::ST_USED;
                mark_next     = mark_reg + 1'b1;
                if ((mark_reg + 1'b1) == want_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    granted_next   = hit_reg;
                    first_frame_next = hit_reg ?
                        (cfg.pool_base + {{(cfa_pkg::FRAME_W-AW){1'b0}}, start_reg}) :
                        '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg        <= want_next;
        iss_reg         <= iss_next;
        ev_off_reg      <= ev_off_next;
        run_reg         <= run_next;
        start_reg       <= start_next;
        mark_reg        <= mark_next;
        granted_reg     <= granted_next;
        first_frame_reg <= first_frame_next;
    end

endmodule

// ----- hdl/contiguous_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_frame_allocator
// First-fit allocator of contiguous frame runs over a 2-bit state store.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   request  | in_valid / in_stall    | req_count
//   result   | out_valid / out_stall  | granted, first_frame
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// A request is scanned through the single store port, one read per offset
// up to the pool limit; a found run is then marked, head frame first, and
// the result is loaded in the done state, then idle takes the next beat.
// After reset all 1024 store entries are cleared one entry a cycle, while
// in_stall stays high. A stalled result holds the next one in its done state;
// one new request is taken while an earlier beat still waits on out_stall.
// ----------------------------------------------------------------------------
module contiguous_frame_allocator (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfa_pkg::FRAME_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cfa_pkg::COUNT_W-1:0]   req_count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [cfa_pkg::FRAME_W-1:0]   first_frame
);

    cfa_pkg::cfg_t     cfg;
    cfa_pkg::mem_req_t mem_req;
    logic [1:0]        mem_rdata;

    cfa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cfa_frame_ram u_ram (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    cfa_scan_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_count   (req_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .granted     (granted),
        .first_frame (first_frame),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

endmodule
